>>> rtl/lmfp_pkg.sv
// shared constants, codes and types of the led matrix frame plotter
package lmfp_pkg;

    localparam int DISPLAY_WIDTH     = 64;
    localparam int DISPLAY_HEIGHT    = 32;
    localparam int CLOCK_BIT         = 6;
    localparam int SCAN_ROWS_MAX_DEF = 16;
    localparam int SLOTS_PER_ROW_DEF = 128;

    localparam int POS_W  = 10;
    localparam int COL_W  = 3;
    localparam int PIX_W  = 2 * COL_W;
    localparam int BYTE_W = 8;
    localparam int SROW_W = 4;
    localparam int LSLOT_W = 7;
    localparam int XW     = $clog2(DISPLAY_WIDTH);
    localparam int YW     = $clog2(DISPLAY_HEIGHT);
    localparam int ROW_W  = 4;
    localparam int SLOT_W = XW + 1;

    localparam logic [BYTE_W-1:0] CLK_MASK = BYTE_W'(1 << CLOCK_BIT);

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_SWAP  = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    localparam logic [1:0] SCAN_4  = 2'd0;
    localparam logic [1:0] SCAN_8  = 2'd1;
    localparam logic [1:0] SCAN_16 = 2'd2;

    localparam logic [1:0] ORIENT_IDENT       = 2'd0;
    localparam logic [1:0] ORIENT_SWAP        = 2'd1;
    localparam logic [1:0] ORIENT_ROT180      = 2'd2;
    localparam logic [1:0] ORIENT_SWAP_MIRROR = 2'd3;

    localparam logic REG_SCAN_MODE   = 1'b0;
    localparam logic REG_ORIENTATION = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FINISH,
        ST_SWEEP
    } state_t;

    typedef struct packed {
        logic              hit;
        logic              lower;
        logic [ROW_W-1:0]  row;
        logic [SLOT_W-1:0] slot;
    } map_t;

endpackage

>>> rtl/lmfp_mapper.sv
// pixel mapper: orientation, screen clipping and scan row / line slot layout
module lmfp_mapper #(
    parameter int SCAN_ROWS_MAX = lmfp_pkg::SCAN_ROWS_MAX_DEF,
    parameter int SLOTS_PER_ROW = lmfp_pkg::SLOTS_PER_ROW_DEF
) (
    input  logic signed [lmfp_pkg::POS_W-1:0] draw_x,
    input  logic signed [lmfp_pkg::POS_W-1:0] draw_y,
    input  logic [1:0]                        scan_mode,
    input  logic [1:0]                        orientation,
    output lmfp_pkg::map_t                    map
);

    localparam int EW = lmfp_pkg::POS_W + 1;
    localparam int XW = lmfp_pkg::XW;
    localparam int YW = lmfp_pkg::YW;
    localparam logic signed [EW-1:0] X_LAST = EW'(lmfp_pkg::DISPLAY_WIDTH - 1);
    localparam logic signed [EW-1:0] Y_LAST = EW'(lmfp_pkg::DISPLAY_HEIGHT - 1);
    localparam logic signed [EW-1:0] X_LIM  = EW'(lmfp_pkg::DISPLAY_WIDTH);
    localparam logic signed [EW-1:0] Y_LIM  = EW'(lmfp_pkg::DISPLAY_HEIGHT);
    localparam logic [YW-1:0]        HALF_H = YW'(lmfp_pkg::DISPLAY_HEIGHT / 2);

    logic                 swap_axes;
    logic                 mirror;
    logic signed [EW-1:0] sx;
    logic signed [EW-1:0] sy;
    logic signed [EW-1:0] ox;
    logic signed [EW-1:0] oy;
    logic                 on_screen;
    logic [XW-1:0]        x;
    logic [YW-1:0]        y;
    logic [YW-1:0]        s;
    logic                 mode_ok;

    always_comb
    begin
        swap_axes = (orientation == lmfp_pkg::ORIENT_SWAP)
                 || (orientation == lmfp_pkg::ORIENT_SWAP_MIRROR);
        mirror    = (orientation == lmfp_pkg::ORIENT_ROT180)
                 || (orientation == lmfp_pkg::ORIENT_SWAP_MIRROR);

        sx = swap_axes ? {draw_y[lmfp_pkg::POS_W-1], draw_y}
                       : {draw_x[lmfp_pkg::POS_W-1], draw_x};
        sy = swap_axes ? {draw_x[lmfp_pkg::POS_W-1], draw_x}
                       : {draw_y[lmfp_pkg::POS_W-1], draw_y};
        ox = mirror ? X_LAST - sx : sx;
        oy = mirror ? Y_LAST - sy : sy;

        on_screen = !ox[EW-1] && !oy[EW-1] && (ox < X_LIM) && (oy < Y_LIM);
        x = ox[XW-1:0];
        y = oy[YW-1:0];

        map.lower = (y >= HALF_H);
        s = map.lower ? y - HALF_H : y;

        mode_ok  = 1'b1;
        map.row  = '0;
        map.slot = '0;
        case (scan_mode)
            lmfp_pkg::SCAN_4:
            begin
                map.row  = lmfp_pkg::ROW_W'(y[1:0]);
                map.slot = lmfp_pkg::SLOT_W'(x);
            end
            lmfp_pkg::SCAN_8:
            begin
                // folded rows: lower half of each 16-slot group runs forward
                if (s >= YW'(8))
                begin
                    map.row  = lmfp_pkg::ROW_W'(s - YW'(8));
                    map.slot = {x[XW-1:3], 1'b0, x[2:0]};
                end
                else
                begin
                    map.row  = lmfp_pkg::ROW_W'(s);
                    map.slot = {x[XW-1:3], 1'b1, ~x[2:0]};
                end
            end
            lmfp_pkg::SCAN_16:
            begin
                map.row  = lmfp_pkg::ROW_W'(y[3:0]);
                map.slot = lmfp_pkg::SLOT_W'(x);
            end
            default:
            begin
                mode_ok = 1'b0;
            end
        endcase

        map.hit = on_screen && mode_ok
               && (32'(map.row) < SCAN_ROWS_MAX)
               && (32'(map.slot) < SLOTS_PER_ROW);
    end

endmodule

>>> rtl/lmfp_store.sv
// frame store memory: one write port, one read port with registered data
module lmfp_store #(
    parameter int DEPTH = 2 * lmfp_pkg::SCAN_ROWS_MAX_DEF * lmfp_pkg::SLOTS_PER_ROW_DEF,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [AW-1:0]              waddr,
    input  logic [lmfp_pkg::PIX_W-1:0] wdata,
    input  logic                       re,
    input  logic [AW-1:0]              raddr,
    output logic [lmfp_pkg::PIX_W-1:0] rdata
);

    logic [lmfp_pkg::PIX_W-1:0] mem [DEPTH];
    logic [lmfp_pkg::PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lmfp_ctrl.sv
// command sequencer: buffer select, sweeps, read-modify-write and result register
module lmfp_ctrl #(
    parameter int SCAN_ROWS_MAX = lmfp_pkg::SCAN_ROWS_MAX_DEF,
    parameter int SLOTS_PER_ROW = lmfp_pkg::SLOTS_PER_ROW_DEF,
    localparam int BUF_ENTRIES   = SCAN_ROWS_MAX * SLOTS_PER_ROW,
    localparam int STORE_ENTRIES = 2 * BUF_ENTRIES,
    localparam int AW            = $clog2(STORE_ENTRIES)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [1:0]                           cmd,
    input  logic signed [lmfp_pkg::POS_W-1:0]    pos_x,
    input  logic signed [lmfp_pkg::POS_W-1:0]    pos_y,
    input  logic [lmfp_pkg::COL_W-1:0]           color,
    input  logic [lmfp_pkg::SROW_W-1:0]          scan_row,
    input  logic [lmfp_pkg::LSLOT_W-1:0]         line_slot,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [lmfp_pkg::BYTE_W-1:0]          data_byte,
    output logic [lmfp_pkg::BYTE_W-1:0]          strobe_byte,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [1:0]                           cfg_data,
    output logic signed [lmfp_pkg::POS_W-1:0]    draw_x,
    output logic signed [lmfp_pkg::POS_W-1:0]    draw_y,
    output logic [1:0]                           scan_mode,
    output logic [1:0]                           orientation,
    input  lmfp_pkg::map_t                       map,
    output logic                                 mem_we,
    output logic [AW-1:0]                        mem_waddr,
    output logic [lmfp_pkg::PIX_W-1:0]           mem_wdata,
    output logic                                 mem_re,
    output logic [AW-1:0]                        mem_raddr,
    input  logic [lmfp_pkg::PIX_W-1:0]           mem_rdata
);

    localparam logic [AW-1:0] BUF_BASE   = AW'(BUF_ENTRIES);
    localparam logic [AW-1:0] BUF_LAST   = AW'(BUF_ENTRIES - 1);
    localparam logic [AW-1:0] STORE_LAST = AW'(STORE_ENTRIES - 1);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(SLOTS_PER_ROW);
    localparam int            CW         = lmfp_pkg::COL_W;
    localparam int            PW         = lmfp_pkg::PIX_W;

    lmfp_pkg::state_t state_reg, state_next;

    logic                               active_reg, active_next;
    logic [1:0]                         scan_mode_reg;
    logic [1:0]                         orient_reg;
    logic [AW-1:0]                      sweep_addr_reg, sweep_addr_next;
    logic [AW-1:0]                      sweep_last_reg, sweep_last_next;
    logic [PW-1:0]                      fill_reg, fill_next;
    logic                               out_valid_reg, out_valid_next;
    logic [PW-1:0]                      out_data_reg, out_data_next;

    logic [1:0]                         cmd_reg;
    logic signed [lmfp_pkg::POS_W-1:0]  pos_x_reg;
    logic signed [lmfp_pkg::POS_W-1:0]  pos_y_reg;
    logic [CW-1:0]                      color_reg;
    logic [lmfp_pkg::SROW_W-1:0]        srow_reg;
    logic [lmfp_pkg::LSLOT_W-1:0]       lslot_reg;
    logic [AW-1:0]                      addr_reg, addr_next;
    logic [PW-1:0]                      pix_reg, pix_next;
    logic                               zero_reg, zero_next;

    logic                               in_accept;
    logic [AW-1:0]                      back_base;
    logic [AW-1:0]                      front_base;
    logic [AW-1:0]                      draw_addr;
    logic [AW-1:0]                      read_addr;
    logic                               read_ok;

    assign in_accept   = in_valid && (state_reg == lmfp_pkg::ST_IDLE);
    assign in_stall    = (state_reg != lmfp_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign data_byte   = lmfp_pkg::BYTE_W'(out_data_reg);
    assign strobe_byte = lmfp_pkg::BYTE_W'(out_data_reg) | lmfp_pkg::CLK_MASK;
    assign draw_x      = pos_x_reg;
    assign draw_y      = pos_y_reg;
    assign scan_mode   = scan_mode_reg;
    assign orientation = orient_reg;

    assign back_base  = active_reg ? '0 : BUF_BASE;
    assign front_base = active_reg ? BUF_BASE : '0;
    assign draw_addr  = back_base + AW'(map.row) * ROW_STRIDE + AW'(map.slot);
    assign read_addr  = front_base + AW'(srow_reg) * ROW_STRIDE + AW'(lslot_reg);
    assign read_ok    = (32'(srow_reg) < SCAN_ROWS_MAX) && (32'(lslot_reg) < SLOTS_PER_ROW);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lmfp_pkg::ST_SWEEP;
            active_reg     <= 1'b0;
            scan_mode_reg  <= lmfp_pkg::SCAN_16;
            orient_reg     <= lmfp_pkg::ORIENT_IDENT;
            sweep_addr_reg <= '0;
            sweep_last_reg <= STORE_LAST;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            active_reg     <= active_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_last_reg <= sweep_last_next;
            fill_reg       <= fill_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == lmfp_pkg::REG_SCAN_MODE)
                begin
                    scan_mode_reg <= cfg_data;
                end
                else
                begin
                    orient_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg   <= cmd;
            pos_x_reg <= pos_x;
            pos_y_reg <= pos_y;
            color_reg <= color;
            srow_reg  <= scan_row;
            lslot_reg <= line_slot;
        end
        addr_reg     <= addr_next;
        pix_reg      <= pix_next;
        zero_reg     <= zero_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_last_next = sweep_last_reg;
        fill_next       = fill_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        addr_next       = addr_reg;
        pix_next        = pix_reg;
        zero_next       = zero_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = mem_rdata | pix_reg;
        mem_re          = 1'b0;
        mem_raddr       = addr_reg;

        // result transfer frees the output register
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            lmfp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (cmd)
                        lmfp_pkg::CMD_CLEAR:
                        begin
                            sweep_addr_next = back_base;
                            sweep_last_next = back_base + BUF_LAST;
                            fill_next       = {color, color};
                            state_next      = lmfp_pkg::ST_SWEEP;
                        end
                        lmfp_pkg::CMD_SWAP:
                        begin
                            active_next = ~active_reg;
                        end
                        lmfp_pkg::CMD_DRAW,
                        lmfp_pkg::CMD_READ:
                        begin
                            state_next = lmfp_pkg::ST_EXEC;
                        end
                        default:
                        begin
                            state_next = lmfp_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            lmfp_pkg::ST_EXEC:
            begin
                if (cmd_reg == lmfp_pkg::CMD_DRAW)
                begin
                    if (map.hit)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = draw_addr;
                        addr_next  = draw_addr;
                        pix_next   = map.lower ? {color_reg, CW'(0)} : {CW'(0), color_reg};
                        state_next = lmfp_pkg::ST_FINISH;
                    end
                    else
                    begin
                        state_next = lmfp_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    zero_next  = !read_ok;
                    mem_re     = read_ok;
                    mem_raddr  = read_addr;
                    state_next = lmfp_pkg::ST_FINISH;
                end
            end
            lmfp_pkg::ST_FINISH:
            begin
                if (cmd_reg == lmfp_pkg::CMD_DRAW)
                begin
                    // write back the or-ed pixel
                    mem_we     = 1'b1;
                    state_next = lmfp_pkg::ST_IDLE;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = zero_reg ? '0 : mem_rdata;
                    state_next     = lmfp_pkg::ST_IDLE;
                end
            end
            lmfp_pkg::ST_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_waddr = sweep_addr_reg;
                mem_wdata = fill_reg;
                if (sweep_addr_reg == sweep_last_reg)
                begin
                    state_next = lmfp_pkg::ST_IDLE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + AW'(1);
                end
            end
            default:
            begin
                state_next = lmfp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/led_matrix_frame_plotter.sv
// Double-buffered frame store for a scanned RGB LED matrix. Both buffers sit in one
// single-port-per-direction memory of 2*SCAN_ROWS_MAX*SLOTS_PER_ROW six-bit entries
// (upper bus half in bits 0-2, lower in bits 3-5). Items are handled one at a time:
// swap is done as it is taken in; draw runs capture, memory read and or-and-write back,
// or ends early when the pixel is dropped as off screen or outside the store;
// read runs capture, memory read and the load of the output register, which holds the
// result until it is transferred while the next item is already taken in; clear writes
// one entry per cycle across the back buffer. After reset the block clears the whole
// memory, one entry per cycle, and holds in_stall high meanwhile; configuration writes are
// taken at any time but are meant to change only while the block is idle.
module led_matrix_frame_plotter #(
    parameter int SCAN_ROWS_MAX = lmfp_pkg::SCAN_ROWS_MAX_DEF,
    parameter int SLOTS_PER_ROW = lmfp_pkg::SLOTS_PER_ROW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        cmd,
    input  logic signed [lmfp_pkg::POS_W-1:0] pos_x,
    input  logic signed [lmfp_pkg::POS_W-1:0] pos_y,
    input  logic [lmfp_pkg::COL_W-1:0]        color,
    input  logic [lmfp_pkg::SROW_W-1:0]       scan_row,
    input  logic [lmfp_pkg::LSLOT_W-1:0]      line_slot,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [lmfp_pkg::BYTE_W-1:0]       data_byte,
    output logic [lmfp_pkg::BYTE_W-1:0]       strobe_byte,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [1:0]                        cfg_data
);

    localparam int STORE_ENTRIES = 2 * SCAN_ROWS_MAX * SLOTS_PER_ROW;
    localparam int AW            = $clog2(STORE_ENTRIES);

    logic signed [lmfp_pkg::POS_W-1:0] draw_x;
    logic signed [lmfp_pkg::POS_W-1:0] draw_y;
    logic [1:0]                        scan_mode;
    logic [1:0]                        orientation;
    lmfp_pkg::map_t                    map;
    logic                              mem_we;
    logic [AW-1:0]                     mem_waddr;
    logic [lmfp_pkg::PIX_W-1:0]        mem_wdata;
    logic                              mem_re;
    logic [AW-1:0]                     mem_raddr;
    logic [lmfp_pkg::PIX_W-1:0]        mem_rdata;

    lmfp_mapper #(
        .SCAN_ROWS_MAX (SCAN_ROWS_MAX),
        .SLOTS_PER_ROW (SLOTS_PER_ROW)
    ) u_mapper (
        .draw_x      (draw_x),
        .draw_y      (draw_y),
        .scan_mode   (scan_mode),
        .orientation (orientation),
        .map         (map)
    );

    lmfp_store #(
        .DEPTH (STORE_ENTRIES)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lmfp_ctrl #(
        .SCAN_ROWS_MAX (SCAN_ROWS_MAX),
        .SLOTS_PER_ROW (SLOTS_PER_ROW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .color       (color),
        .scan_row    (scan_row),
        .line_slot   (line_slot),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_byte   (data_byte),
        .strobe_byte (strobe_byte),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .draw_x      (draw_x),
        .draw_y      (draw_y),
        .scan_mode   (scan_mode),
        .orientation (orientation),
        .map         (map),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

endmodule
